// ===== rtl/can_id_mask_filter_table_core_defines.svh =====
// Assertion macros for the CAN identifier mask filter table.
// Used by the port checker; depends on nothing else.
`ifndef CAN_ID_MASK_FILTER_TABLE_CORE_DEFINES_SVH
`define CAN_ID_MASK_FILTER_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, masked during reset.
`define CMFT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, masked during reset.
`define CMFT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/cmft_pkg.sv =====
// Shared types and constants for the CAN identifier mask filter table.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package cmft_pkg;

   // Field widths.
   localparam int IDENT_W = 11;
   localparam int INDEX_W = 8;
   localparam int LEN_W   = 4;
   localparam int DATA_W  = 64;
   localparam int CFG_W   = 6;
   // Width wide enough to compare any entry count or index.
   localparam int CMP_W   = 9;

   // Defaults and reset values.
   localparam int                 DEF_NUM_FILTERS = 32;
   localparam logic [CFG_W-1:0]   CFG_RESET       = 6'd32;
   localparam logic [IDENT_W-1:0] IDENT_ALL       = 11'h7FF;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_FRAME = 1'b1
   } op_type;

   typedef enum logic {
      ST_OK      = 1'b0,
      ST_BAD_ARG = 1'b1
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WRITE,
      S_SCAN
   } state_type;

   // Write request from the sequencer to the filter table.
   typedef struct packed {
      logic               wr_en;
      logic               mask_en;
      logic [IDENT_W-1:0] ident;
      logic [IDENT_W-1:0] mask;
   } tbl_wr_type;

   // Entry read back from the table, with unwritten fields at their reset value.
   typedef struct packed {
      logic               armed;
      logic [IDENT_W-1:0] ident;
      logic [IDENT_W-1:0] mask;
   } tbl_rd_type;

endpackage

// ===== rtl/cmft_table.sv =====
// Filter entry storage: identifier and mask memories with per-entry written flags.
// Depends on cmft_pkg.
`timescale 1ns / 1ps

module cmft_table #(
   parameter int NUM_FILTERS = cmft_pkg::DEF_NUM_FILTERS,
   parameter int IDX_W       = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmft_pkg::tbl_wr_type wr,
   input  logic [IDX_W-1:0]     wr_addr,
   input  logic [IDX_W-1:0]     rd_addr,
   output cmft_pkg::tbl_rd_type rd
);

   // Each entry keeps its full eleven-bit identifier and its full eleven-bit mask.
   logic [cmft_pkg::IDENT_W-1:0] ident_mem [NUM_FILTERS];
   logic [cmft_pkg::IDENT_W-1:0] mask_mem  [NUM_FILTERS];

   logic [NUM_FILTERS-1:0]       armed_ff;
   logic [NUM_FILTERS-1:0]       mask_set_ff;
   logic [cmft_pkg::IDENT_W-1:0] ident_q_ff;
   logic [cmft_pkg::IDENT_W-1:0] mask_q_ff;
   logic                         armed_q_ff;
   logic                         mask_set_q_ff;

   // Memory write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr.wr_en) begin
         ident_mem[wr_addr] <= wr.ident;
      end
      if (wr.wr_en && wr.mask_en) begin
         mask_mem[wr_addr] <= wr.mask;
      end
      ident_q_ff <= ident_mem[rd_addr];
      mask_q_ff  <= mask_mem[rd_addr];
   end

   // Written flags; reset returns every entry to its reset value at once.
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff      <= '0;
         mask_set_ff   <= '0;
         armed_q_ff    <= 1'b0;
         mask_set_q_ff <= 1'b0;
      end else begin
         if (wr.wr_en) begin
            armed_ff[wr_addr] <= 1'b1;
            if (wr.mask_en) begin
               mask_set_ff[wr_addr] <= 1'b1;
            end
         end
         armed_q_ff    <= armed_ff[rd_addr];
         mask_set_q_ff <= mask_set_ff[rd_addr];
      end
   end

   // An unwritten identifier reads as zero and an unwritten mask as all ones.
   always_comb begin
      rd.armed = armed_q_ff;
      rd.ident = armed_q_ff ? ident_q_ff : '0;
      rd.mask  = mask_set_q_ff ? mask_q_ff : cmft_pkg::IDENT_ALL;
   end

endmodule

// ===== rtl/cmft_seq.sv =====
// Sequencer and shared compare unit: executes entry writes and scans the table
// one entry per cycle for a received frame. Depends on cmft_pkg.
`timescale 1ns / 1ps

module cmft_seq #(
   parameter int NUM_FILTERS = cmft_pkg::DEF_NUM_FILTERS,
   parameter int IDX_W       = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1,
   parameter int CNT_W       = $clog2(NUM_FILTERS + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_opcode,
   input  logic [cmft_pkg::INDEX_W-1:0]        req_entry_index,
   input  logic [cmft_pkg::IDENT_W-1:0]        req_entry_ident,
   input  logic [cmft_pkg::IDENT_W-1:0]        req_entry_mask,
   input  logic                                req_entry_rtr,
   input  logic [cmft_pkg::IDENT_W-1:0]        req_frame_ident,
   input  logic [cmft_pkg::LEN_W-1:0]          req_frame_length,
   input  logic [cmft_pkg::DATA_W-1:0]         req_frame_data,
   input  logic [cmft_pkg::CFG_W-1:0]          filters_in_use,
   output cmft_pkg::tbl_wr_type                wr,
   output logic [IDX_W-1:0]                    wr_addr,
   output logic [IDX_W-1:0]                    rd_addr,
   input  cmft_pkg::tbl_rd_type                rd,
   output logic                                rsp_valid,
   output logic                                rsp_status,
   output logic                                rsp_matched,
   output logic [cmft_pkg::INDEX_W-1:0]        rsp_match_index,
   output logic [cmft_pkg::IDENT_W-1:0]        rsp_out_ident,
   output logic [cmft_pkg::LEN_W-1:0]          rsp_out_length,
   output logic [cmft_pkg::DATA_W-1:0]         rsp_out_data
);

   cmft_pkg::state_type state_ff, state_in;

   // Scan control.
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic             chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;

   // Captured item.
   logic                         load_item;
   logic [cmft_pkg::INDEX_W-1:0] idx_ff;
   logic [cmft_pkg::IDENT_W-1:0] e_ident_ff;
   logic [cmft_pkg::IDENT_W-1:0] e_mask_ff;
   logic                         e_rtr_ff;
   logic [cmft_pkg::IDENT_W-1:0] f_ident_ff;
   logic [cmft_pkg::LEN_W-1:0]   f_len_ff;
   logic [cmft_pkg::DATA_W-1:0]  f_data_ff;

   // Result registers.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_status_ff, rsp_status_in;
   logic                         rsp_matched_ff, rsp_matched_in;
   logic [cmft_pkg::INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [cmft_pkg::IDENT_W-1:0] rsp_ident_ff, rsp_ident_in;
   logic [cmft_pkg::LEN_W-1:0]   rsp_len_ff, rsp_len_in;
   logic [cmft_pkg::DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0] n_eff;
   logic             idx_bad;
   logic             issue_lt;
   logic             hit;
   logic             last;

   // Effective entry count, the write range check and the shared compare unit.
   always_comb begin
      if (cmft_pkg::CMP_W'(filters_in_use) > cmft_pkg::CMP_W'(NUM_FILTERS)) begin
         n_eff = CNT_W'(NUM_FILTERS);
      end else begin
         n_eff = CNT_W'(filters_in_use);
      end
      idx_bad  = cmft_pkg::CMP_W'(idx_ff) >= cmft_pkg::CMP_W'(n_eff);
      issue_lt = issue_ff < n_eff;
      hit      = ((f_ident_ff ^ rd.ident) & rd.mask) == '0;
      last     = (CNT_W'(chk_idx_ff) + CNT_W'(1)) == n_eff;
      rd_addr  = issue_lt ? issue_ff[IDX_W-1:0] : '0;
      wr_addr  = idx_ff[IDX_W-1:0];
   end

   // Next state and outputs.
   always_comb begin
      state_in       = state_ff;
      issue_in       = issue_ff;
      chk_vld_in     = 1'b0;
      chk_idx_in     = issue_ff[IDX_W-1:0];
      load_item      = 1'b0;
      wr             = '0;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_matched_in = rsp_matched_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_ident_in   = rsp_ident_ff;
      rsp_len_in     = rsp_len_ff;
      rsp_data_in    = rsp_data_ff;

      case (state_ff)
         cmft_pkg::S_IDLE: begin
            if (start) begin
               load_item = 1'b1;
               issue_in  = '0;
               state_in  = (req_opcode == cmft_pkg::OP_WRITE) ? cmft_pkg::S_WRITE
                                                               : cmft_pkg::S_SCAN;
            end
         end

         cmft_pkg::S_WRITE: begin
            // Store the entry unless the index lies outside the entries in use.
            wr.wr_en       = ~idx_bad;
            wr.mask_en     = ~e_rtr_ff;
            wr.ident       = e_ident_ff;
            wr.mask        = e_mask_ff;
            rsp_valid_in   = 1'b1;
            rsp_status_in  = idx_bad ? cmft_pkg::ST_BAD_ARG : cmft_pkg::ST_OK;
            rsp_matched_in = 1'b0;
            rsp_index_in   = '0;
            rsp_ident_in   = '0;
            rsp_len_in     = '0;
            rsp_data_in    = '0;
            state_in       = cmft_pkg::S_IDLE;
         end

         cmft_pkg::S_SCAN: begin
            // Issue one read a cycle; the compare runs on the entry read last cycle.
            if (issue_lt) begin
               chk_vld_in = 1'b1;
               issue_in   = issue_ff + CNT_W'(1);
            end
            rsp_status_in = cmft_pkg::ST_OK;
            if (chk_vld_ff && hit) begin
               // The first matching entry ends the search; only an armed one delivers.
               chk_vld_in     = 1'b0;
               rsp_valid_in   = 1'b1;
               rsp_matched_in = rd.armed;
               rsp_index_in   = rd.armed ? cmft_pkg::INDEX_W'(chk_idx_ff) : '0;
               rsp_ident_in   = rd.armed ? f_ident_ff : '0;
               rsp_len_in     = rd.armed ? f_len_ff : '0;
               rsp_data_in    = rd.armed ? f_data_ff : '0;
               state_in       = cmft_pkg::S_IDLE;
            end else if ((chk_vld_ff && last) || (n_eff == '0)) begin
               chk_vld_in     = 1'b0;
               rsp_valid_in   = 1'b1;
               rsp_matched_in = 1'b0;
               rsp_index_in   = '0;
               rsp_ident_in   = '0;
               rsp_len_in     = '0;
               rsp_data_in    = '0;
               state_in       = cmft_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = cmft_pkg::S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cmft_pkg::S_IDLE;
         issue_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      chk_idx_ff     <= chk_idx_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_ident_ff   <= rsp_ident_in;
      rsp_len_ff     <= rsp_len_in;
      rsp_data_ff    <= rsp_data_in;
      if (load_item) begin
         idx_ff     <= req_entry_index;
         e_ident_ff <= req_entry_ident;
         e_mask_ff  <= req_entry_mask;
         e_rtr_ff   <= req_entry_rtr;
         f_ident_ff <= req_frame_ident;
         f_len_ff   <= req_frame_length;
         f_data_ff  <= req_frame_data;
      end
   end

   assign busy            = (state_ff != cmft_pkg::S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_matched     = rsp_matched_ff;
   assign rsp_match_index = rsp_index_ff;
   assign rsp_out_ident   = rsp_ident_ff;
   assign rsp_out_length  = rsp_len_ff;
   assign rsp_out_data    = rsp_data_ff;

endmodule

// ===== rtl/can_id_mask_filter_table_core.sv =====
// CAN receive acceptance filter table (identifier and mask match), top level.
// Depends on cmft_pkg, cmft_table and cmft_seq.
//
// Usage: an item is taken when start is high and busy is low. Opcode write
// stores one filter entry; opcode frame searches the table for the first
// entry whose masked identifier matches. Each item gives one result, shown on
// the rsp_ ports for a single cycle with rsp_valid high; the receiver cannot
// stall it, so it must take every result as it appears.
// The csr_ channel writes filters_in_use; csr_ready is always high, and writes
// are expected only while the block is idle.
// A write gives its result from the write state, which stores the entry only
// if its index lies within the entries in use. A frame scan ends at its first
// matching entry, after the last entry in use, or at once with none in use.
// The scan reads one entry a cycle from the table memory through a single
// compare unit, which sets the frame rate. The next item may be taken in the
// cycle its predecessor's result is shown.
// Reset clears the sequencer and marks every entry unwritten, so all entries
// read as identifier zero with an all-ones mask, and sets filters_in_use to 32.
`timescale 1ns / 1ps

module can_id_mask_filter_table_core #(
   parameter int NUM_FILTERS = cmft_pkg::DEF_NUM_FILTERS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_opcode,
   input  logic [cmft_pkg::INDEX_W-1:0]  req_entry_index,
   input  logic [cmft_pkg::IDENT_W-1:0]  req_entry_ident,
   input  logic [cmft_pkg::IDENT_W-1:0]  req_entry_mask,
   input  logic                          req_entry_rtr,
   input  logic [cmft_pkg::IDENT_W-1:0]  req_frame_ident,
   input  logic [cmft_pkg::LEN_W-1:0]    req_frame_length,
   input  logic [cmft_pkg::DATA_W-1:0]   req_frame_data,
   output logic                          rsp_valid,
   output logic                          rsp_status,
   output logic                          rsp_matched,
   output logic [cmft_pkg::INDEX_W-1:0]  rsp_match_index,
   output logic [cmft_pkg::IDENT_W-1:0]  rsp_out_ident,
   output logic [cmft_pkg::LEN_W-1:0]    rsp_out_length,
   output logic [cmft_pkg::DATA_W-1:0]   rsp_out_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cmft_pkg::CFG_W-1:0]    csr_data
);

   localparam int IDX_W = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;
   localparam int CNT_W = $clog2(NUM_FILTERS + 1);

   logic [cmft_pkg::CFG_W-1:0] fiu_ff;
   cmft_pkg::tbl_wr_type       wr;
   cmft_pkg::tbl_rd_type       rd;
   logic [IDX_W-1:0]           wr_addr;
   logic [IDX_W-1:0]           rd_addr;

   // Configuration register: every transfer is taken at once.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fiu_ff <= cmft_pkg::CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         fiu_ff <= csr_data;
      end
   end

   cmft_seq #(
      .NUM_FILTERS (NUM_FILTERS),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_entry_index  (req_entry_index),
      .req_entry_ident  (req_entry_ident),
      .req_entry_mask   (req_entry_mask),
      .req_entry_rtr    (req_entry_rtr),
      .req_frame_ident  (req_frame_ident),
      .req_frame_length (req_frame_length),
      .req_frame_data   (req_frame_data),
      .filters_in_use   (fiu_ff),
      .wr               (wr),
      .wr_addr          (wr_addr),
      .rd_addr          (rd_addr),
      .rd               (rd),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_matched      (rsp_matched),
      .rsp_match_index  (rsp_match_index),
      .rsp_out_ident    (rsp_out_ident),
      .rsp_out_length   (rsp_out_length),
      .rsp_out_data     (rsp_out_data)
   );

   cmft_table #(
      .NUM_FILTERS (NUM_FILTERS),
      .IDX_W       (IDX_W)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .wr_addr (wr_addr),
      .rd_addr (rd_addr),
      .rd      (rd)
   );

endmodule

// ===== rtl/cmft_chk.sv =====
// Port checker for the CAN identifier mask filter table, bound to the top level.
// Depends on cmft_pkg and can_id_mask_filter_table_core_defines.svh.
`timescale 1ns / 1ps
`include "can_id_mask_filter_table_core_defines.svh"

module cmft_chk (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic                          rsp_status,
   input logic                          rsp_matched,
   input logic [cmft_pkg::INDEX_W-1:0]  rsp_match_index,
   input logic [cmft_pkg::IDENT_W-1:0]  rsp_out_ident,
   input logic [cmft_pkg::LEN_W-1:0]    rsp_out_length,
   input logic [cmft_pkg::DATA_W-1:0]   rsp_out_data
);

   // A transfer on the request side makes the block busy in the next cycle.
   `CMFT_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "busy not raised after transfer")

   // A result is only shown once the item's work has finished.
   `CMFT_ASSERT_NOW(a_idle_with_rsp, rsp_valid, !busy, "result shown while busy")

   // Results are single-cycle pulses.
   `CMFT_ASSERT_NEXT(a_rsp_pulse, rsp_valid, !rsp_valid, "result held for two cycles")

   // A result without a delivered frame carries all-zero frame fields.
   `CMFT_ASSERT_NOW(a_zero_no_match, rsp_valid && !rsp_matched, (rsp_match_index == '0) && (rsp_out_ident == '0) && (rsp_out_length == '0) && (rsp_out_data == '0), "frame fields not zero without a match")

   // A rejected write never reports a match.
   `CMFT_ASSERT_NOW(a_bad_arg_no_match, rsp_valid && (rsp_status == cmft_pkg::ST_BAD_ARG), !rsp_matched, "match reported with rejected write")

endmodule

bind can_id_mask_filter_table_core cmft_chk u_chk (.*);
